FILE: design/multichannel_moving_average_top_assert.svh
// Assertion helpers used by the top-level design file.
`ifndef MULTICHANNEL_MOVING_AVERAGE_TOP_ASSERT_SVH
`define MULTICHANNEL_MOVING_AVERAGE_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MMA_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MMA_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/mma_pkg.sv
package mma_pkg;

    // Sizing of the stores. Channel indexes are 6 bits wide on the bus,
    // so CHANNELS stays at or below 64.
    localparam int CHANNELS   = 64;
    localparam int WINDOW_MAX = 64;

    localparam int CH_W    = 6;   // channel field
    localparam int SMP_W   = 8;   // sample field
    localparam int AVG_W   = 8;   // average field, also quotient width
    localparam int WIN_W   = 7;   // window_size register
    localparam int SUM_W   = 14;  // running sum per channel
    localparam int FRM_W   = 7;   // saturating frame counter
    localparam int DATA_W  = 16;  // tdata width on both channels

    localparam int CH_AW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SLOT_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int HIST_AW = SLOT_W + CH_AW;
    localparam int HIST_DEPTH = 1 << HIST_AW;

    localparam int DIV_W   = SUM_W + 1;
    localparam int QCNT_W  = $clog2(AVG_W);
    localparam int MUL_W   = SMP_W + WIN_W;
    localparam int IN_PAD_W  = DATA_W - CH_W - SMP_W;
    localparam int OUT_PAD_W = DATA_W - CH_W - AVG_W;

    localparam logic [FRM_W-1:0] FRAMES_SAT = {FRM_W{1'b1}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_WR,
        ST_FILL,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage

FILE: design/multichannel_moving_average_top.sv
// Moving average over the last window_size frames, per sensor channel.
// Input stream (s_*): one word per channel sample; s_tlast marks the last
// sample of a frame and moves the history slot pointer on. Result stream
// (m_*): one word per input word, carrying the channel and the truncated
// mean of its last window_size samples.
// Config channel (cfg_*): writes window_size (0 acts as 1, values above
// 64 act as 64) and restarts the history; taken only while no word is in
// flight. The first frame after reset or a write fills every slot.
// State: a 4096 x 8 history RAM addressed by {slot, channel} and a
// 64 x 14 running-sum RAM, both with a registered read port; each word
// does read, modify, write back before the next one is taken, so the two
// accesses of successive words never overlap.
// Steps per word: read, update, restoring divide, result load; during the
// first frame a slot fill sweep over window_size slots comes before the
// divide, one history write per cycle.
// A stalled m_tready holds the result in the output register while the
// next word is already taken and worked on; it waits only at the load.
// Reset: window_size 1, sums read as zero, slot and frame count cleared.
`include "multichannel_moving_average_top_assert.svh"

module multichannel_moving_average_top (
    input  logic        aclk,
    input  logic        aresetn,
    // sample stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [5:0] channel, [13:6] sample, [15:14] zero
    input  logic        s_tlast,   // last_of_frame
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [5:0] out_channel, [13:6] average, [15:14] zero
    // window_size write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_wdata
);

    // ---------------------------------------------------------------
    // Control state
    // ---------------------------------------------------------------
    mma_pkg::state_t state_reg, state_next;

    logic [mma_pkg::WIN_W-1:0]    win_reg;
    logic [mma_pkg::SLOT_W-1:0]   slot_reg;
    logic [mma_pkg::FRM_W-1:0]    frames_reg;
    logic [mma_pkg::CHANNELS-1:0] sum_vld_reg;
    logic                         m_tvalid_reg;

    // Word in flight
    logic [mma_pkg::CH_W-1:0]     ch_reg;
    logic [mma_pkg::SMP_W-1:0]    smp_reg;
    logic                         last_reg;
    logic                         inr_reg;
    logic [mma_pkg::SUM_W-1:0]    sum_reg;
    logic [mma_pkg::SLOT_W-1:0]   fill_cnt_reg;

    // Divider
    logic [mma_pkg::DIV_W-1:0]    rem_reg;
    logic [mma_pkg::DIV_W-1:0]    dvs_reg;
    logic [mma_pkg::AVG_W-1:0]    quo_reg;
    logic [mma_pkg::QCNT_W-1:0]   dstep_reg;

    logic [mma_pkg::DATA_W-1:0]   m_tdata_reg;

    // Memories and their read data
    logic [mma_pkg::SMP_W-1:0] hist_mem [mma_pkg::HIST_DEPTH];
    logic [mma_pkg::SUM_W-1:0] sum_mem  [mma_pkg::CHANNELS];
    logic [mma_pkg::SMP_W-1:0] hist_rdata_reg;
    logic [mma_pkg::SUM_W-1:0] sum_rdata_reg;

    // Strobes from the state machine
    logic                         in_acc;
    logic                         cfg_acc;
    logic                         hist_we;
    logic [mma_pkg::HIST_AW-1:0]  hist_waddr;
    logic                         sum_we;
    logic                         out_load;

    // Input field views
    logic [mma_pkg::CH_W-1:0]     s_ch;
    logic [mma_pkg::SMP_W-1:0]    s_smp;
    logic [mma_pkg::CH_AW-1:0]    s_ch_addr;
    logic [mma_pkg::CH_AW-1:0]    ch_addr;

    // Datapath helpers
    logic [mma_pkg::WIN_W-1:0]    cfg_win;
    logic [mma_pkg::MUL_W-1:0]    fill_prod;
    logic [mma_pkg::SUM_W-1:0]    sum_base;
    logic [mma_pkg::SUM_W-1:0]    sum_upd;
    logic                         fill_last;
    logic                         slot_wrap;
    logic                         div_ge;

    assign s_ch      = s_tdata[mma_pkg::CH_W-1:0];
    assign s_smp     = s_tdata[mma_pkg::CH_W +: mma_pkg::SMP_W];
    assign s_ch_addr = mma_pkg::CH_AW'(s_ch);
    assign ch_addr   = mma_pkg::CH_AW'(ch_reg);

    assign in_acc  = s_tvalid && s_tready;
    assign cfg_acc = cfg_valid && cfg_ready;

    // Clamp the written window into 1..WINDOW_MAX.
    always_comb begin
        if (cfg_wdata == '0) begin
            cfg_win = mma_pkg::WIN_W'(1);
        end else if (32'(cfg_wdata) > mma_pkg::WINDOW_MAX) begin
            cfg_win = mma_pkg::WIN_W'(mma_pkg::WINDOW_MAX);
        end else begin
            cfg_win = cfg_wdata;
        end
    end

    // First frame: every slot holds this sample, so the sum is sample * window.
    assign fill_prod = mma_pkg::MUL_W'(smp_reg) * mma_pkg::MUL_W'(win_reg);

    // Later frames: swap the current slot's old sample for the new one.
    assign sum_base = sum_vld_reg[ch_addr] ? sum_rdata_reg : '0;
    assign sum_upd  = sum_base + mma_pkg::SUM_W'(smp_reg) - mma_pkg::SUM_W'(hist_rdata_reg);

    assign fill_last = (mma_pkg::WIN_W'(fill_cnt_reg) + mma_pkg::WIN_W'(1)) >= win_reg;
    assign slot_wrap = (mma_pkg::WIN_W'(slot_reg) + mma_pkg::WIN_W'(1)) >= win_reg;
    assign div_ge    = rem_reg >= dvs_reg;

    // ---------------------------------------------------------------
    // State machine
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mma_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cfg_ready  = 1'b0;
        hist_we    = 1'b0;
        hist_waddr = {slot_reg, ch_addr};
        sum_we     = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            mma_pkg::ST_IDLE: begin
                s_tready  = 1'b1;
                cfg_ready = 1'b1;
                if (s_tvalid) begin
                    state_next = mma_pkg::ST_RD;
                end
            end
            mma_pkg::ST_RD: begin
                // read data lands here; the new sum is formed into sum_reg
                state_next = mma_pkg::ST_WR;
            end
            mma_pkg::ST_WR: begin
                if (!inr_reg) begin
                    // channel outside the store: result is zero
                    state_next = mma_pkg::ST_OUT;
                end else if (frames_reg == '0) begin
                    sum_we     = 1'b1;
                    state_next = mma_pkg::ST_FILL;
                end else begin
                    sum_we     = 1'b1;
                    hist_we    = 1'b1;
                    state_next = mma_pkg::ST_DIV;
                end
            end
            mma_pkg::ST_FILL: begin
                hist_we    = 1'b1;
                hist_waddr = {fill_cnt_reg, ch_addr};
                if (fill_last) begin
                    state_next = mma_pkg::ST_DIV;
                end
            end
            mma_pkg::ST_DIV: begin
                if (dstep_reg == '0) begin
                    state_next = mma_pkg::ST_OUT;
                end
            end
            mma_pkg::ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = mma_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mma_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg      <= mma_pkg::WIN_W'(1);
            slot_reg     <= '0;
            frames_reg   <= '0;
            sum_vld_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_acc) begin
                // restart the history under the new window
                win_reg     <= cfg_win;
                slot_reg    <= '0;
                frames_reg  <= '0;
                sum_vld_reg <= '0;
            end
            if (sum_we) begin
                sum_vld_reg[ch_addr] <= 1'b1;
            end
            // advance the frame after this word's slot has been used
            if ((state_reg == mma_pkg::ST_WR) && last_reg) begin
                slot_reg <= slot_wrap ? '0 : slot_reg + mma_pkg::SLOT_W'(1);
                if (frames_reg != mma_pkg::FRAMES_SAT) begin
                    frames_reg <= frames_reg + mma_pkg::FRM_W'(1);
                end
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Datapath registers
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            ch_reg   <= s_ch;
            smp_reg  <= s_smp;
            last_reg <= s_tlast;
            inr_reg  <= 32'(s_ch) < mma_pkg::CHANNELS;
        end
        case (state_reg)
            mma_pkg::ST_RD: begin
                sum_reg <= (frames_reg == '0) ? mma_pkg::SUM_W'(fill_prod) : sum_upd;
            end
            mma_pkg::ST_WR: begin
                fill_cnt_reg <= '0;
                rem_reg      <= mma_pkg::DIV_W'(sum_reg);
                dvs_reg      <= mma_pkg::DIV_W'(win_reg) << (mma_pkg::AVG_W - 1);
                quo_reg      <= '0;
                dstep_reg    <= mma_pkg::QCNT_W'(mma_pkg::AVG_W - 1);
            end
            mma_pkg::ST_FILL: begin
                fill_cnt_reg <= fill_cnt_reg + mma_pkg::SLOT_W'(1);
            end
            mma_pkg::ST_DIV: begin
                // one quotient bit per cycle, most significant first
                if (div_ge) begin
                    rem_reg <= rem_reg - dvs_reg;
                end
                quo_reg   <= {quo_reg[mma_pkg::AVG_W-2:0], div_ge};
                dvs_reg   <= dvs_reg >> 1;
                dstep_reg <= dstep_reg - mma_pkg::QCNT_W'(1);
            end
            default: begin
            end
        endcase
        if (out_load) begin
            m_tdata_reg <= {{mma_pkg::OUT_PAD_W{1'b0}}, quo_reg, ch_reg};
        end
    end

    // ---------------------------------------------------------------
    // Memories: one write and one registered read port each
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (hist_we) begin
            hist_mem[hist_waddr] <= smp_reg;
        end
        if (in_acc) begin
            hist_rdata_reg <= hist_mem[{slot_reg, s_ch_addr}];
        end
    end

    always_ff @(posedge aclk) begin
        if (sum_we) begin
            sum_mem[ch_addr] <= sum_reg;
        end
        if (in_acc) begin
            sum_rdata_reg <= sum_mem[s_ch_addr];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    `MMA_ASSERT_IMP(a_slot_in_window, aclk, aresetn, 1'b1,
        mma_pkg::WIN_W'(slot_reg) < win_reg, "slot pointer outside window")
    `MMA_ASSERT_IMP(a_win_range, aclk, aresetn, 1'b1,
        (win_reg != '0) && (32'(win_reg) <= mma_pkg::WINDOW_MAX), "window out of range")
    `MMA_ASSERT_IMP(a_no_write_idle, aclk, aresetn, hist_we || sum_we,
        state_reg != mma_pkg::ST_IDLE, "store written with no word in flight")
    `MMA_ASSERT_NXT(a_out_no_overwrite, aclk, aresetn, m_tvalid && !m_tready,
        $stable(m_tdata), "pending result overwritten")

endmodule
